### sv/qolm_pkg.sv
// Package: types, constants and fixed-point helpers for the observer/LQR mixer.
`timescale 1ns / 1ps
package qolm_pkg;

	localparam int FRAC_BITS = 16;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] gyro_x;
		logic signed [31:0] gyro_y;
		logic signed [31:0] gyro_z;
		logic signed [31:0] accel_z;
		logic signed [31:0] flow_x;
		logic signed [31:0] flow_y;
		logic signed [31:0] range;
		logic               motors_off;
		logic               clear_estimate;
	} in_item_t;

	typedef struct packed {
		logic [15:0] motor_one;
		logic [15:0] motor_two;
		logic [15:0] motor_three;
		logic [15:0] motor_four;
	} out_item_t;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WB, ST_DONE} st_t;

	typedef enum logic [5:0] {
		OP_WX, OP_WY, OP_WZ, OP_AZ, OP_NXE, OP_NYE, OP_RZ, OP_PZ, OP_PX, OP_PY,
		OP_YA, OP_TH, OP_PI, OP_PH, OP_RO, OP_VXG, OP_VXL, OP_VX, OP_VYG, OP_VYL,
		OP_VY, OP_VZL, OP_VZ, OP_TX0, OP_TX1, OP_TX2, OP_TX3, OP_TY0, OP_TY1,
		OP_TY2, OP_TY3, OP_TZ0, OP_TZ1, OP_FZ0, OP_FZ1, OP_MIX
	} op_t;

	// Observer constants, Q24
	localparam logic signed [31:0] K_D2R  = 32'sd292818;
	localparam logic signed [31:0] K_G    = 32'sd164584489;
	localparam logic signed [31:0] K_FLOW = 32'sd68661691;
	localparam logic signed [31:0] K_DT   = 32'sd33554;
	localparam logic signed [31:0] L_RZ   = 32'sd331535790;
	localparam logic signed [31:0] L_TH   = 32'sd250098;
	localparam logic signed [31:0] L_PH   = 32'sd203474;
	localparam logic signed [31:0] L_VX   = 32'sd3508519;
	localparam logic signed [31:0] L_VY   = 32'sd3663674;
	localparam logic signed [31:0] L_VZ   = 32'sd1631584256;

	// Controller gains, Q32, with their signs folded in
	localparam logic signed [31:0] C_PY  = 32'sd13913203;
	localparam logic signed [31:0] NC_RO = -32'sd23231349;
	localparam logic signed [31:0] C_VY  = 32'sd8581345;
	localparam logic signed [31:0] NC_WX = -32'sd2620102;
	localparam logic signed [31:0] NC_PX = -32'sd10777147;
	localparam logic signed [31:0] NC_PI = -32'sd23066766;
	localparam logic signed [31:0] NC_VX = -32'sd8368959;
	localparam logic signed [31:0] NC_WY = -32'sd2616022;
	localparam logic signed [31:0] NC_YA = -32'sd1977059;
	localparam logic signed [31:0] NC_WZ = -32'sd680452;
	localparam logic signed [31:0] NC_PZ = -32'sd927547709;
	localparam logic signed [31:0] NC_VZ = -32'sd541920544;
	localparam logic signed [63:0] FB_TERM = 64'sd1348276134 <<< FRAC_BITS;

	localparam logic signed [31:0] MIX_A = 32'sd3968254;
	localparam logic signed [31:0] MIX_B = 32'sd116822430;
	localparam logic signed [31:0] MIX_C = 32'sd119048;

	// Gravity in signal format, rounded half up from Q24
	localparam logic signed [63:0] GF_WIDE = (FRAC_BITS == 24) ? 64'(K_G) :
		((64'(K_G) + (64'sd1 <<< (23 - FRAC_BITS))) >>> (24 - FRAC_BITS));
	localparam logic signed [31:0] GF = GF_WIDE[31:0];

	localparam logic signed [63:0] TAU_LIM = 64'sd1 <<< 33;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Product of a signal and a Q24 constant back to signal format
	function automatic logic signed [31:0] mq_rnd(input logic signed [63:0] p);
		return sat32((p + (64'sd1 <<< 23)) >>> 24);
	endfunction

	function automatic logic signed [34:0] tau_clamp(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > TAU_LIM)
			r = TAU_LIM;
		if (r < -TAU_LIM)
			r = -TAU_LIM;
		return r[34:0];
	endfunction

	function automatic logic [15:0] motor_sat(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + (64'sd1 <<< 31)) >>> 32;
		if (r < 64'sd0)
			return 16'd0;
		if (r > 64'sd65535)
			return 16'hffff;
		return r[15:0];
	endfunction

	// Mixer sign pattern: motor m, term j (roll, pitch, yaw, thrust)
	function automatic logic signed [31:0] mix_coef(input logic [1:0] m, input logic [1:0] j);
		logic signed [31:0] c;
		case (j)
			2'd0: c = (m[1]) ? MIX_A : -MIX_A;
			2'd1: c = (m == 2'd1 || m == 2'd2) ? MIX_A : -MIX_A;
			2'd2: c = (m[0]) ? MIX_B : -MIX_B;
			default: c = MIX_C;
		endcase
		return c;
	endfunction

endpackage

### sv/qolm_channels.sv
// Handshake channels for sensor items and motor command items.
`timescale 1ns / 1ps
interface qolm_in_if;
	import qolm_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qolm_out_if;
	import qolm_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/qolm_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module qolm_mul
	import qolm_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [35:0] a,
	input  logic signed [31:0] k,
	output logic signed [63:0] p_q
);
	logic signed [67:0] full;

	assign full = a * k;

	always_ff @(posedge clk) begin
		if (en)
			p_q <= full[63:0];
	end
endmodule

### sv/quad_observer_lqr_mixer_unit.sv
// Observer, LQR and motor mixer built around one shared multiplier.
//  channel   | dir  | payload
//  sensors   | sink | targets, gyro, accel, flow, range, flags
//  motors    | src  | four 16-bit motor commands
// Each item runs 51 products through the shared multiplier, each with an issue
// and a writeback state, between the accept in idle and the result state.
// sensors.ready is high only while idle; the result holds until taken.
// Reset clears the nine estimates and the sequencer.
`timescale 1ns / 1ps
module quad_observer_lqr_mixer_unit
	import qolm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	qolm_in_if.sink          sensors,
	qolm_out_if.source       motors
);
	st_t  st_q, st_nxt;
	op_t  op_q;
	logic [3:0] mix_q;
	logic issue, wb_last;

	logic signed [31:0] tx_q, ty_q, tz_q, gx_q, gy_q, gz_q, ax_q, nx_q, ny_q, rg_q;
	logic moff_q;
	logic signed [31:0] px_q, py_q, pz_q, ya_q, pi_q, ro_q, vx_q, vy_q, vz_q;
	logic signed [31:0] wx_q, wy_q, wz_q, az_q, nxe_q, nye_q, re_q;
	logic signed [63:0] aux_q;
	logic signed [34:0] taux_q, tauy_q, tauz_q, fz_q;
	logic [15:0] mot_q [4];

	logic signed [35:0] mul_a;
	logic signed [31:0] mul_k;
	logic signed [63:0] prod;
	logic signed [31:0] t;
	logic signed [63:0] acc;
	logic signed [34:0] tau_sel;

	qolm_mul u_mul (.clk(clk), .en(issue), .a(mul_a), .k(mul_k), .p_q(prod));

	assign t   = mq_rnd(prod);
	assign acc = aux_q + prod;
	assign wb_last = (op_q == OP_MIX) && (mix_q == 4'd15);

	always_comb begin
		case (mix_q[1:0])
			2'd0: tau_sel = taux_q;
			2'd1: tau_sel = tauy_q;
			2'd2: tau_sel = tauz_q;
			default: tau_sel = fz_q;
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_k = '0;
		case (op_q)
			OP_WX:  begin mul_a = 36'(gx_q); mul_k = K_D2R; end
			OP_WY:  begin mul_a = 36'(gy_q); mul_k = K_D2R; end
			OP_WZ:  begin mul_a = 36'(gz_q); mul_k = K_D2R; end
			OP_AZ:  begin mul_a = 36'(ax_q); mul_k = K_G; end
			OP_NXE: begin
				mul_a = 36'(sat32((64'(vx_q) <<< 1) - 64'(wy_q)));
				mul_k = K_FLOW;
			end
			OP_NYE: begin
				mul_a = 36'(sat32((64'(vy_q) <<< 1) + 64'(wx_q)));
				mul_k = K_FLOW;
			end
			OP_RZ:  begin mul_a = 36'(re_q); mul_k = L_RZ; end
			OP_PZ:  begin mul_a = aux_q[35:0]; mul_k = K_DT; end
			OP_PX:  begin mul_a = 36'(vx_q); mul_k = K_DT; end
			OP_PY:  begin mul_a = 36'(vy_q); mul_k = K_DT; end
			OP_YA:  begin mul_a = 36'(wz_q); mul_k = K_DT; end
			OP_TH:  begin mul_a = 36'(nxe_q); mul_k = L_TH; end
			OP_PI:  begin mul_a = aux_q[35:0]; mul_k = K_DT; end
			OP_PH:  begin mul_a = 36'(nye_q); mul_k = L_PH; end
			OP_RO:  begin mul_a = aux_q[35:0]; mul_k = K_DT; end
			OP_VXG: begin mul_a = 36'(pi_q); mul_k = K_G; end
			OP_VXL: begin mul_a = 36'(nxe_q); mul_k = L_VX; end
			OP_VX:  begin mul_a = aux_q[35:0]; mul_k = K_DT; end
			OP_VYG: begin mul_a = 36'(ro_q); mul_k = K_G; end
			OP_VYL: begin mul_a = 36'(nye_q); mul_k = L_VY; end
			OP_VY:  begin mul_a = aux_q[35:0]; mul_k = K_DT; end
			OP_VZL: begin mul_a = 36'(re_q); mul_k = L_VZ; end
			OP_VZ:  begin mul_a = aux_q[35:0]; mul_k = K_DT; end
			OP_TX0: begin mul_a = 36'(sat32(64'(py_q) - 64'(ty_q))); mul_k = C_PY; end
			OP_TX1: begin mul_a = 36'(ro_q); mul_k = NC_RO; end
			OP_TX2: begin mul_a = 36'(vy_q); mul_k = C_VY; end
			OP_TX3: begin mul_a = 36'(wx_q); mul_k = NC_WX; end
			OP_TY0: begin mul_a = 36'(sat32(64'(px_q) - 64'(tx_q))); mul_k = NC_PX; end
			OP_TY1: begin mul_a = 36'(pi_q); mul_k = NC_PI; end
			OP_TY2: begin mul_a = 36'(vx_q); mul_k = NC_VX; end
			OP_TY3: begin mul_a = 36'(wy_q); mul_k = NC_WY; end
			OP_TZ0: begin mul_a = 36'(ya_q); mul_k = NC_YA; end
			OP_TZ1: begin mul_a = 36'(wz_q); mul_k = NC_WZ; end
			OP_FZ0: begin mul_a = 36'(sat32(64'(pz_q) - 64'(tz_q))); mul_k = NC_PZ; end
			OP_FZ1: begin mul_a = 36'(vz_q); mul_k = NC_VZ; end
			OP_MIX: begin mul_a = 36'(tau_sel); mul_k = mix_coef(mix_q[3:2], mix_q[1:0]); end
			default: begin mul_a = '0; mul_k = '0; end
		endcase
	end

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE:  if (sensors.valid) st_nxt = ST_ISSUE;
			ST_ISSUE: st_nxt = ST_WB;
			ST_WB:    st_nxt = wb_last ? ST_DONE : ST_ISSUE;
			ST_DONE:  if (motors.ready) st_nxt = ST_IDLE;
			default:  st_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		sensors.ready = (st_q == ST_IDLE);
		motors.valid  = (st_q == ST_DONE);
		issue         = (st_q == ST_ISSUE);
	end

	assign motors.data.motor_one   = moff_q ? 16'd0 : mot_q[0];
	assign motors.data.motor_two   = moff_q ? 16'd0 : mot_q[1];
	assign motors.data.motor_three = moff_q ? 16'd0 : mot_q[2];
	assign motors.data.motor_four  = moff_q ? 16'd0 : mot_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			op_q  <= OP_WX;
			mix_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			ya_q <= '0; pi_q <= '0; ro_q <= '0;
			vx_q <= '0; vy_q <= '0; vz_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (sensors.valid && sensors.ready) begin
				op_q  <= OP_WX;
				mix_q <= '0;
				if (sensors.data.clear_estimate) begin
					px_q <= '0; py_q <= '0; pz_q <= '0;
					ya_q <= '0; pi_q <= '0; ro_q <= '0;
					vx_q <= '0; vy_q <= '0; vz_q <= '0;
				end
			end
			if (st_q == ST_WB) begin
				if (op_q == OP_MIX)
					mix_q <= mix_q + 4'd1;
				else
					op_q <= op_t'(op_q + 6'd1);
				case (op_q)
					OP_PZ: pz_q <= sat32(64'(pz_q) + 64'(t));
					OP_PX: px_q <= sat32(64'(px_q) + 64'(t));
					OP_PY: py_q <= sat32(64'(py_q) + 64'(t));
					OP_YA: ya_q <= sat32(64'(ya_q) + 64'(t));
					OP_PI: pi_q <= sat32(64'(pi_q) + 64'(t));
					OP_RO: ro_q <= sat32(64'(ro_q) + 64'(t));
					OP_VX: vx_q <= sat32(64'(vx_q) + 64'(t));
					OP_VY: vy_q <= sat32(64'(vy_q) + 64'(t));
					OP_VZ: vz_q <= sat32(64'(vz_q) + 64'(t));
					default: ;
				endcase
			end
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		if (sensors.valid && sensors.ready) begin
			tx_q <= sensors.data.target_x;
			ty_q <= sensors.data.target_y;
			tz_q <= sensors.data.target_z;
			gx_q <= sensors.data.gyro_x;
			gy_q <= sensors.data.gyro_y;
			gz_q <= sensors.data.gyro_z;
			ax_q <= sensors.data.accel_z;
			nx_q <= sensors.data.flow_x;
			ny_q <= sensors.data.flow_y;
			rg_q <= sensors.data.range;
			moff_q <= sensors.data.motors_off;
		end
		if (st_q == ST_WB) begin
			case (op_q)
				OP_WX: begin
					wx_q <= t;
					re_q <= sat32(64'(pz_q) - 64'(rg_q));
				end
				OP_WY:  wy_q <= t;
				OP_WZ:  wz_q <= t;
				OP_AZ:  az_q <= t;
				OP_NXE: nxe_q <= sat32(64'(t) - 64'(nx_q));
				OP_NYE: nye_q <= sat32(64'(t) - 64'(ny_q));
				OP_RZ:  aux_q <= 64'(sat32(64'(vz_q) - 64'(t)));
				OP_TH:  aux_q <= 64'(sat32(64'(wy_q) - 64'(t)));
				OP_PH:  aux_q <= 64'(sat32(64'(wx_q) + 64'(t)));
				OP_VXG: aux_q <= 64'(t);
				OP_VXL: aux_q <= 64'(sat32(aux_q - 64'(t)));
				OP_VYG: aux_q <= -64'(t);
				OP_VYL: aux_q <= 64'(sat32(aux_q - 64'(t)));
				OP_VZL: aux_q <= 64'(sat32(64'(sat32(64'(az_q) - 64'(GF))) - 64'(t)));
				OP_TX0, OP_TY0, OP_TZ0: aux_q <= prod;
				OP_FZ0: aux_q <= prod + FB_TERM;
				OP_TX1, OP_TX2, OP_TY1, OP_TY2: aux_q <= acc;
				OP_TX3: taux_q <= tau_clamp(acc);
				OP_TY3: tauy_q <= tau_clamp(acc);
				OP_TZ1: tauz_q <= tau_clamp(acc);
				OP_FZ1: fz_q <= tau_clamp(acc);
				OP_MIX: begin
					if (mix_q[1:0] == 2'd0)
						aux_q <= prod;
					else
						aux_q <= acc;
					if (mix_q[1:0] == 2'd3)
						mot_q[mix_q[3:2]] <= motor_sat(acc);
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		motors.valid |-> !sensors.ready) else $error("item accepted while result pending");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(sensors.valid && sensors.ready) |=> (st_q == ST_ISSUE && op_q == OP_WX))
		else $error("sequencer did not start at first op");
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(motors.valid && moff_q) |-> (motors.data.motor_one == 16'd0 &&
		motors.data.motor_four == 16'd0)) else $error("motors not zero while off");
	a_done_after_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(motors.valid) |-> $past(op_q) == OP_MIX) else $error("result before mixer");
`endif
endmodule

### dv/quad_observer_lqr_mixer_checker.sv
// Checker: predicts motor commands from accepted sensor items and compares them.
`timescale 1ns / 1ps
module quad_observer_lqr_mixer_checker
	import qolm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	qolm_in_if   sensors,
	qolm_out_if  motors,
	output int   errors,
	output int   pending,
	output int   results
);

	// observer constants, Q24
	localparam longint Q_D2R  = 292818;
	localparam longint Q_G    = 164584489;
	localparam longint Q_FLOW = 68661691;
	localparam longint Q_DT   = 33554;
	localparam longint G_RZ   = 331535790;
	localparam longint G_TH   = 250098;
	localparam longint G_PH   = 203474;
	localparam longint G_VX   = 3508519;
	localparam longint G_VY   = 3663674;
	localparam longint G_VZ   = 1631584256;
	// controller gains, Q32
	localparam longint K_PY = 13913203;
	localparam longint K_RO = 23231349;
	localparam longint K_VY = 8581345;
	localparam longint K_WX = 2620102;
	localparam longint K_PX = 10777147;
	localparam longint K_PI = 23066766;
	localparam longint K_VX = 8368959;
	localparam longint K_WY = 2616022;
	localparam longint K_YA = 1977059;
	localparam longint K_WZ = 680452;
	localparam longint K_PZ = 927547709;
	localparam longint K_VZ = 541920544;
	localparam longint K_FB = 1348276134;
	localparam longint M_A  = 3968254;
	localparam longint M_B  = 116822430;
	localparam longint M_C  = 119048;

	longint est_px, est_py, est_pz, est_ya, est_pi, est_ro, est_vx, est_vy, est_vz;
	out_item_t expected_cmds[$];

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rshift_round(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint qmul(longint x, longint k);
		return clip32(rshift_round(x * k, 24));
	endfunction

	function automatic longint clamp_tau(longint v);
		longint lim;
		lim = 64'sd1 <<< 33;
		v = rshift_round(v, FRAC_BITS);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic logic [15:0] motor_cmd(longint v);
		longint m;
		m = rshift_round(v, 32);
		if (m < 0)
			return 16'd0;
		if (m > 65535)
			return 16'hffff;
		return m[15:0];
	endfunction

	// advance the observer by one step and return the motor commands
	function automatic out_item_t predict_motors(in_item_t s);
		longint tx, ty, tz, wx, wy, wz, az, nx, ny, rg, gf;
		longint nxe, nye, re, tau_x, tau_y, tau_z, thrust;
		out_item_t r;
		tx = s.target_x;
		ty = s.target_y;
		tz = s.target_z;
		wx = qmul(longint'(s.gyro_x), Q_D2R);
		wy = qmul(longint'(s.gyro_y), Q_D2R);
		wz = qmul(longint'(s.gyro_z), Q_D2R);
		az = qmul(longint'(s.accel_z), Q_G);
		nx = s.flow_x;
		ny = s.flow_y;
		rg = s.range;
		gf = rshift_round(Q_G, 24 - FRAC_BITS);
		if (s.clear_estimate) begin
			est_px = 0; est_py = 0; est_pz = 0;
			est_ya = 0; est_pi = 0; est_ro = 0;
			est_vx = 0; est_vy = 0; est_vz = 0;
		end
		nxe = clip32(qmul(clip32(2 * est_vx - wy), Q_FLOW) - nx);
		nye = clip32(qmul(clip32(2 * est_vy + wx), Q_FLOW) - ny);
		re = clip32(est_pz - rg);
		est_px = clip32(est_px + qmul(est_vx, Q_DT));
		est_py = clip32(est_py + qmul(est_vy, Q_DT));
		est_pz = clip32(est_pz + qmul(clip32(est_vz - qmul(re, G_RZ)), Q_DT));
		est_ya = clip32(est_ya + qmul(wz, Q_DT));
		est_pi = clip32(est_pi + qmul(clip32(wy - qmul(nxe, G_TH)), Q_DT));
		est_ro = clip32(est_ro + qmul(clip32(wx + qmul(nye, G_PH)), Q_DT));
		// velocities use the tilt angles just updated
		est_vx = clip32(est_vx + qmul(clip32(qmul(est_pi, Q_G) - qmul(nxe, G_VX)), Q_DT));
		est_vy = clip32(est_vy + qmul(clip32(-qmul(est_ro, Q_G) - qmul(nye, G_VY)), Q_DT));
		est_vz = clip32(est_vz + qmul(clip32(clip32(az - gf) - qmul(re, G_VZ)), Q_DT));
		r = '0;
		if (s.motors_off)
			return r;
		tau_x = K_PY * clip32(est_py - ty) - K_RO * est_ro + K_VY * est_vy - K_WX * wx;
		tau_y = -K_PX * clip32(est_px - tx) - K_PI * est_pi - K_VX * est_vx - K_WY * wy;
		tau_z = -K_YA * est_ya - K_WZ * wz;
		thrust = -K_PZ * clip32(est_pz - tz) - K_VZ * est_vz + (K_FB <<< FRAC_BITS);
		tau_x = clamp_tau(tau_x);
		tau_y = clamp_tau(tau_y);
		tau_z = clamp_tau(tau_z);
		thrust = clamp_tau(thrust);
		r.motor_one   = motor_cmd(-M_A * tau_x - M_A * tau_y - M_B * tau_z + M_C * thrust);
		r.motor_two   = motor_cmd(-M_A * tau_x + M_A * tau_y + M_B * tau_z + M_C * thrust);
		r.motor_three = motor_cmd(M_A * tau_x + M_A * tau_y - M_B * tau_z + M_C * thrust);
		r.motor_four  = motor_cmd(M_A * tau_x - M_A * tau_y + M_B * tau_z + M_C * thrust);
		return r;
	endfunction

	assign pending = expected_cmds.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			est_px = 0; est_py = 0; est_pz = 0;
			est_ya = 0; est_pi = 0; est_ro = 0;
			est_vx = 0; est_vy = 0; est_vz = 0;
			expected_cmds.delete();
			errors = 0;
			results = 0;
		end else begin
			if (motors.valid && motors.ready) begin
				results++;
				if (expected_cmds.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: motor item %h with nothing expected", motors.data);
				end else begin
					want = expected_cmds.pop_front();
					if (motors.data.motor_one !== want.motor_one ||
							motors.data.motor_two !== want.motor_two ||
							motors.data.motor_three !== want.motor_three ||
							motors.data.motor_four !== want.motor_four) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: result %0d motors exp %0d %0d %0d %0d got %0d %0d %0d %0d",
								results, want.motor_one, want.motor_two, want.motor_three,
								want.motor_four, motors.data.motor_one, motors.data.motor_two,
								motors.data.motor_three, motors.data.motor_four);
					end
				end
			end
			if (sensors.valid && sensors.ready)
				expected_cmds.push_back(predict_motors(sensors.data));
		end
	end

endmodule

### dv/quad_observer_lqr_mixer_unit_test.sv
// Testbench top: clock, reset, sensor stimulus, motor back-pressure and verdict.
`timescale 1ns / 1ps
module quad_observer_lqr_mixer_unit_test;
	import qolm_pkg::*;

	localparam int RANDOM_ITEMS = 1050;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int   errors, pending, results;
	int   sent, off_cnt, clear_cnt;
	int   hold_cycles;
	longint cycles;

	qolm_in_if  sensors ();
	qolm_out_if motors ();

	quad_observer_lqr_mixer_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensors (sensors.sink),
		.motors  (motors.source)
	);

	quad_observer_lqr_mixer_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensors (sensors),
		.motors  (motors),
		.errors  (errors),
		.pending (pending),
		.results (results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// small plausible signal: uniform in -span..span, in Q16.16
	function automatic logic signed [31:0] mild(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_item(in_item_t s, int gap);
		if (gap > 0) begin
			sensors.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensors.valid = 1'b1;
		sensors.data = s;
		while (!sensors.ready)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		sent++;
		off_cnt += s.motors_off;
		clear_cnt += s.clear_estimate;
	endtask

	task automatic run_directed();
		in_item_t s;
		int i;
		s = '0;
		send_item(s, 0);
		s.range = 32'sh0000_8000;
		send_item(s, 1);
		s = '1;
		send_item(s, 0);
		s = '0;
		s.clear_estimate = 1'b1;
		send_item(s, 0);
		for (i = 0; i < 10; i++) begin
			s.target_x = 32'sh7fffffff; s.target_y = 32'sh7fffffff; s.target_z = 32'sh7fffffff;
			s.gyro_x = 32'sh7fffffff; s.gyro_y = 32'sh7fffffff; s.gyro_z = 32'sh7fffffff;
			s.accel_z = 32'sh7fffffff; s.flow_x = 32'sh7fffffff; s.flow_y = 32'sh7fffffff;
			s.range = 32'sh7fffffff;
			s.motors_off = (i == 3);
			s.clear_estimate = (i == 0);
			// five items at max, then five at min, saturate the estimates both ways
			if (i >= 5) begin
				s.target_x = 32'sh80000000; s.target_y = 32'sh80000000;
				s.target_z = 32'sh80000000; s.gyro_x = 32'sh80000000;
				s.gyro_y = 32'sh80000000; s.gyro_z = 32'sh80000000;
				s.accel_z = 32'sh80000000; s.flow_x = 32'sh80000000;
				s.flow_y = 32'sh80000000; s.range = 32'sh80000000;
			end
			send_item(s, 0);
		end
		s = '0;
		s.clear_estimate = 1'b1;
		s.target_z = 32'sh0001_0000;
		s.accel_z = 32'sh0001_0000;
		send_item(s, 2);
		s.clear_estimate = 1'b0;
		s.motors_off = 1'b1;
		send_item(s, 0);
		s.motors_off = 1'b0;
		s.gyro_z = 32'sh0100_0000;
		s.range = -32'sh0002_0000;
		send_item(s, 0);
	endtask

	task automatic run_random();
		in_item_t s;
		int i;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 200)
				hold_cycles = 1500;
			if ($urandom_range(0, 9) < 8) begin
				s.target_x = mild(32'sh0002_0000);
				s.target_y = mild(32'sh0002_0000);
				s.target_z = mild(32'sh0002_0000);
				s.gyro_x = mild(32'sh0050_0000);
				s.gyro_y = mild(32'sh0050_0000);
				s.gyro_z = mild(32'sh0050_0000);
				s.accel_z = 32'sh0001_0000 + mild(32'sh0000_4000);
				s.flow_x = mild(32'sh0004_0000);
				s.flow_y = mild(32'sh0004_0000);
				s.range = mild(32'sh0002_0000);
				s.motors_off = ($urandom_range(0, 19) == 0);
				s.clear_estimate = ($urandom_range(0, 39) == 0);
			end else begin
				s.target_x = $urandom(); s.target_y = $urandom(); s.target_z = $urandom();
				s.gyro_x = $urandom(); s.gyro_y = $urandom(); s.gyro_z = $urandom();
				s.accel_z = $urandom(); s.flow_x = $urandom(); s.flow_y = $urandom();
				s.range = $urandom();
				s.motors_off = $urandom_range(0, 1);
				s.clear_estimate = $urandom_range(0, 1);
			end
			send_item(s, pick_gap());
		end
		sensors.valid = 1'b0;
	endtask

	// motor side: random stalls, plus one long hold-off on request
	initial begin
		int run;
		motors.ready = 1'b0;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				motors.ready = 1'b0;
				hold_cycles--;
			end else if (run > 0) begin
				run--;
			end else begin
				motors.ready = ($urandom_range(0, 3) != 0);
				run = motors.ready ? $urandom_range(0, 40) : pick_gap();
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("ERROR: timeout after %0d cycles, %0d results outstanding", cycles, pending);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sensors.valid = 1'b0;
		sensors.data = '0;
		sent = 0;
		off_cnt = 0;
		clear_cnt = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		while (pending != 0)
			@(negedge clk);
		repeat (250) @(negedge clk);
		$display("Sent %0d sensor items (%0d motors off, %0d clears), checked %0d motor items",
			sent, off_cnt, clear_cnt, results);
		$display("Covered field extremes, saturation, long output hold-off, %0d errors", errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
